### rtl/protected_branch_target_decoder_top_defines.svh
// Assertion macros shared by the checker of the protected branch target decoder.
`ifndef PROTECTED_BRANCH_TARGET_DECODER_TOP_DEFINES_SVH
`define PROTECTED_BRANCH_TARGET_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PBTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PBTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pbtd_pkg.sv
// Package with item types, codes and decode functions of the branch target decoder.
package pbtd_pkg;

    localparam int unsigned WORD_BYTES = 4;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [31:0] ADDR_MASK = 32'hF0F0_F0F0;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] EXEC_MASK = 32'hC000_0000;

    localparam logic [1:0] KIND_LOAD      = 2'd0;
    localparam logic [1:0] KIND_TRAP      = 2'd1;
    localparam logic [1:0] KIND_DIV_FAULT = 2'd2;
    localparam logic [1:0] KIND_MEM_FAULT = 2'd3;

    localparam logic [1:0] ACT_SKIP   = 2'd0;
    localparam logic [1:0] ACT_RETURN = 2'd1;
    localparam logic [1:0] ACT_JUMP   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_BASE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b1;

    // Upper eight opcode bits of the load/store groups decoded for a data fault.
    localparam logic [7:0] OPG_WORD_IMM   = 8'hE5;
    localparam logic [7:0] OPG_WORD_POST  = 8'hE4;
    localparam logic [7:0] OPG_HALF_IMM   = 8'hE1;
    localparam logic [7:0] OPG_HALF_POST  = 8'hE0;
    localparam logic [7:0] OPG_MULTIPLE   = 8'hE8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KEY,
        S_VER,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  entry_index;
        logic [31:0] entry_key;
        logic [31:0] entry_value;
        logic [31:0] pc_value;
        logic [31:0] instruction_word;
        logic [31:0] stack_word;
        logic [31:0] link_value;
        logic [31:0] numerator_value;
        logic [31:0] fault_addr;
    } t_in_item;

    typedef struct packed {
        logic [31:0] destination;
        logic        valid_res;
        logic [1:0]  action;
        logic [31:0] new_pc;
        logic        pops_stack;
    } t_out_item;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
    } t_entry;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] link;
        logic        pops;
    } t_dec;

    function automatic logic [31:0] decode_value(input logic [31:0] v,
                                                 input logic [31:0] base);
        return v ^ base ^ ADDR_MASK;
    endfunction

    // Destination of a data fault taken from the load/store immediate.
    function automatic logic [31:0] ldst_dest(input logic [31:0] ins,
                                              input logic [31:0] fault,
                                              input logic [31:0] pc);
        logic        hit;
        logic        plus;
        logic [31:0] imm;
        logic [31:0] addr;
        logic [3:0]  n;
        n    = ins[23:20];
        hit  = 1'b0;
        plus = n[3];
        imm  = 32'({ins[11:8], ins[3:0]});
        case (ins[31:24])
            OPG_WORD_IMM: begin
                hit = 1'b1;
                imm = 32'(ins[11:0]);
            end
            OPG_WORD_POST: begin
                hit = !n[1];
                imm = 32'(ins[11:0]);
            end
            OPG_HALF_IMM: begin
                hit = n[2];
            end
            OPG_HALF_POST: begin
                hit = n[2] && !n[1];
            end
            OPG_MULTIPLE: begin
                hit  = (n[3:1] == 3'b100);
                plus = 1'b1;
                imm  = 32'd0;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        addr = plus ? (fault + imm) : (fault - imm);
        return hit ? (addr ^ pc ^ ALL_ONES) : 32'd0;
    endfunction

endpackage

### rtl/protected_branch_target_decoder_top.sv
// Top level of the protected branch target decoder.
// Load item: written to the table when accepted; the next item may follow in the next cycle.
// Trap item: a key scan, then a verify scan, each over at most N = min(entry_count,
// MAX_ENTRIES) entries, one table read per cycle on one memory port.
// Fault items: the verify scan alone.
// Synchronous active-low reset clears control and configuration; the table is undefined.
module protected_branch_target_decoder_top #(
    parameter int unsigned MAX_ENTRIES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pbtd_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pbtd_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_we,
    input  logic [pbtd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                    i_cfg_wdata
);

    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

    pbtd_pkg::t_dec   dec;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    pbtd_pkg::t_entry wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    pbtd_pkg::t_entry rd_data;

    pbtd_dec u_dec (
        .i_item (i_in_data),
        .o_dec  (dec)
    );

    pbtd_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pbtd_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_dec       (dec),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

endmodule

### rtl/pbtd_table.sv
// Target table memory holding key/value entries with a registered read port.
module pbtd_table #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  pbtd_pkg::t_entry i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output pbtd_pkg::t_entry o_rd_data
);

    pbtd_pkg::t_entry r_mem [DEPTH];
    pbtd_pkg::t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

### rtl/pbtd_dec.sv
// Destination decoder for divide faults and memory faults; for traps it sets only the stack pop and link.
module pbtd_dec (
    input  pbtd_pkg::t_in_item i_item,
    output pbtd_pkg::t_dec     o_dec
);

    always_comb begin
        o_dec.dest = 32'd0;
        o_dec.link = i_item.link_value;
        o_dec.pops = 1'b0;
        case (i_item.kind)
            pbtd_pkg::KIND_TRAP: begin
                o_dec.pops = 1'b1;
            end
            pbtd_pkg::KIND_DIV_FAULT: begin
                o_dec.dest = i_item.numerator_value ^ pbtd_pkg::ALL_ONES ^ i_item.pc_value;
            end
            pbtd_pkg::KIND_MEM_FAULT: begin
                if (i_item.fault_addr == i_item.pc_value) begin
                    o_dec.dest = i_item.fault_addr ^ pbtd_pkg::EXEC_MASK;
                    o_dec.pops = 1'b1;
                    o_dec.link = i_item.stack_word;
                end else begin
                    o_dec.dest = pbtd_pkg::ldst_dest(i_item.instruction_word,
                                                     i_item.fault_addr,
                                                     i_item.pc_value);
                end
            end
            default: begin
                o_dec.dest = 32'd0;
            end
        endcase
    end

endmodule

### rtl/pbtd_ctrl.sv
// Sequencer for table loads, key search, target verification and the result register.
module pbtd_ctrl #(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned AW          = 6,
    parameter int unsigned CW          = 7
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  pbtd_pkg::t_in_item               i_in_data,
    input  pbtd_pkg::t_dec                   i_dec,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output pbtd_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [pbtd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                      i_cfg_wdata,
    output logic                             o_wr_en,
    output logic [AW-1:0]                    o_wr_addr,
    output pbtd_pkg::t_entry                 o_wr_data,
    output logic                             o_rd_en,
    output logic [AW-1:0]                    o_rd_addr,
    input  pbtd_pkg::t_entry                 i_rd_data
);

    pbtd_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_len, n_len;
    logic                r_pend, n_pend;
    logic                r_ok, n_ok;
    logic [31:0]         r_dest, n_dest;
    logic [31:0]         r_link, n_link;
    logic [31:0]         r_pc, n_pc;
    logic [31:0]         r_key, n_key;
    logic                r_pops, n_pops;
    logic                r_ovalid, n_ovalid;
    pbtd_pkg::t_out_item r_out, n_out;
    logic [31:0]         r_map_base, n_map_base;
    logic [6:0]          r_entry_count, n_entry_count;

    logic                accept;
    logic                issue;
    logic [31:0]         cnt_ext;
    logic [31:0]         slot_ext;
    logic [CW-1:0]       search_len;
    logic [31:0]         rd_dest;

    assign accept   = i_in_valid && o_in_ready;
    assign issue    = (r_idx < r_len);
    assign cnt_ext  = 32'(r_entry_count);
    assign slot_ext = 32'(i_in_data.entry_index);
    assign rd_dest  = pbtd_pkg::decode_value(i_rd_data.value, r_map_base);
    assign search_len = (cnt_ext > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cnt_ext[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= pbtd_pkg::S_IDLE;
            r_idx         <= '0;
            r_len         <= '0;
            r_pend        <= 1'b0;
            r_ovalid      <= 1'b0;
            r_map_base    <= 32'd0;
            r_entry_count <= 7'd0;
        end else begin
            r_state       <= n_state;
            r_idx         <= n_idx;
            r_len         <= n_len;
            r_pend        <= n_pend;
            r_ovalid      <= n_ovalid;
            r_map_base    <= n_map_base;
            r_entry_count <= n_entry_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok   <= n_ok;
        r_dest <= n_dest;
        r_link <= n_link;
        r_pc   <= n_pc;
        r_key  <= n_key;
        r_pops <= n_pops;
        r_out  <= n_out;
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_len         = r_len;
        n_pend        = r_pend;
        n_ok          = r_ok;
        n_dest        = r_dest;
        n_link        = r_link;
        n_pc          = r_pc;
        n_key         = r_key;
        n_pops        = r_pops;
        n_ovalid      = r_ovalid;
        n_out         = r_out;
        n_map_base    = r_map_base;
        n_entry_count = r_entry_count;
        o_in_ready    = 1'b0;
        o_wr_en       = 1'b0;
        o_wr_addr     = slot_ext[AW-1:0];
        o_wr_data.key   = i_in_data.entry_key;
        o_wr_data.value = i_in_data.entry_value;
        o_rd_en       = 1'b0;
        o_rd_addr     = r_idx[AW-1:0];

        if (i_cfg_we) begin
            case (i_cfg_idx)
                pbtd_pkg::REG_MAP_BASE:    n_map_base    = i_cfg_wdata;
                pbtd_pkg::REG_ENTRY_COUNT: n_entry_count = i_cfg_wdata[6:0];
                default:                   n_map_base    = r_map_base;
            endcase
        end

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            pbtd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    if (i_in_data.kind == pbtd_pkg::KIND_LOAD) begin
                        o_wr_en = (slot_ext < 32'(MAX_ENTRIES));
                    end else begin
                        n_pc    = i_in_data.pc_value;
                        n_key   = i_in_data.stack_word;
                        n_link  = i_dec.link;
                        n_pops  = i_dec.pops;
                        n_dest  = i_dec.dest;
                        n_idx   = '0;
                        n_len   = search_len;
                        n_pend  = 1'b0;
                        n_state = (i_in_data.kind == pbtd_pkg::KIND_TRAP) ?
                                  pbtd_pkg::S_KEY : pbtd_pkg::S_VER;
                    end
                end
            end
            pbtd_pkg::S_KEY: begin
                o_rd_en = issue;
                n_pend  = issue;
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (r_pend && (i_rd_data.key == r_key)) begin
                    n_dest  = rd_dest;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = pbtd_pkg::S_VER;
                end else if (!issue && !r_pend) begin
                    n_dest  = 32'd0;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = pbtd_pkg::S_VER;
                end
            end
            pbtd_pkg::S_VER: begin
                if (r_dest == r_map_base) begin
                    n_ok    = 1'b1;
                    n_pend  = 1'b0;
                    n_state = pbtd_pkg::S_DONE;
                end else begin
                    o_rd_en = issue;
                    n_pend  = issue;
                    if (issue) begin
                        n_idx = r_idx + CW'(1);
                    end
                    if (r_pend && (rd_dest == r_dest)) begin
                        n_ok    = 1'b1;
                        n_pend  = 1'b0;
                        n_state = pbtd_pkg::S_DONE;
                    end else if (!issue && !r_pend) begin
                        n_ok    = 1'b0;
                        n_state = pbtd_pkg::S_DONE;
                    end
                end
            end
            pbtd_pkg::S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_out.destination = r_dest;
                    n_out.valid_res   = r_ok;
                    n_out.action      = pbtd_pkg::ACT_SKIP;
                    n_out.new_pc      = 32'd0;
                    n_out.pops_stack  = 1'b0;
                    if (r_ok) begin
                        n_out.pops_stack = r_pops;
                        if (r_dest == r_map_base) begin
                            n_out.action = pbtd_pkg::ACT_RETURN;
                            n_out.new_pc = r_link;
                        end else if (r_dest == 32'd0) begin
                            n_out.new_pc = r_pc + 32'(pbtd_pkg::WORD_BYTES);
                        end else begin
                            n_out.action = pbtd_pkg::ACT_JUMP;
                            n_out.new_pc = r_dest;
                        end
                    end
                    n_ovalid = 1'b1;
                    n_state  = pbtd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pbtd_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

### rtl/pbtd_checker.sv
// Port-level checker of the protected branch target decoder and its bind.
`include "protected_branch_target_decoder_top_defines.svh"

module pbtd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input pbtd_pkg::t_out_item i_out_data
);

    logic out_stall;
    logic out_bad;
    logic bad_clear;
    logic out_jump;
    logic jump_match;
    logic out_skip;
    logic dest_zero;

    assign out_stall  = i_out_valid && !i_out_ready;
    assign out_bad    = i_out_valid && !i_out_data.valid_res;
    assign bad_clear  = (i_out_data.action == pbtd_pkg::ACT_SKIP) &&
                        (i_out_data.new_pc == 32'd0) && !i_out_data.pops_stack;
    assign out_jump   = i_out_valid && i_out_data.valid_res &&
                        (i_out_data.action == pbtd_pkg::ACT_JUMP);
    assign jump_match = (i_out_data.new_pc == i_out_data.destination);
    assign out_skip   = i_out_valid && i_out_data.valid_res &&
                        (i_out_data.action == pbtd_pkg::ACT_SKIP);
    assign dest_zero  = (i_out_data.destination == 32'd0);

    `PBTD_ASSERT_NEXT(a_out_hold, out_stall, i_out_valid && $stable(i_out_data), "result not held")
    `PBTD_ASSERT_NOW(a_invalid_zero, out_bad, bad_clear, "invalid result has nonzero fields")
    `PBTD_ASSERT_NOW(a_jump_pc, out_jump, jump_match, "jump pc differs from destination")
    `PBTD_ASSERT_NOW(a_skip_zero, out_skip, dest_zero, "skip with nonzero destination")

endmodule

bind protected_branch_target_decoder_top pbtd_checker u_pbtd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
